FILE: src/chmap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chmap_pkg: shared types and constants for the chained hash map engine
// Command codes, field widths and default sizes.
// ----------------------------------------------------------------------------
package chmap_pkg;
   localparam int NumBucketsDefault = 128;
   localparam int NumEntriesDefault = 256;
   localparam int KeyWidth = 31;
   localparam int ValueWidth = 32;

   typedef enum logic [1:0] {
      CMD_GET = 2'd0,
      CMD_PUT = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_INCR = 2'd3
   } cmd_type;
endpackage

FILE: src/chained_hash_map_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_map_engine_core: key to value map with separate chaining
// Bucket heads, entry pool and free list; a sequencer walks the chains.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one transaction: command, lookup_key, data_value.
//   rsp_ channel returns one transaction per request: read_value, key_found,
//   pool_full. A transaction moves when valid is high and stall is low.
//   The block takes one request at a time; req_stall is high while a request
//   is in work. A finished response waits in the rsp_ registers, so the next
//   request can be taken while it waits.
//   Steps from the accepting edge to rsp_valid: a reciprocal key reduction
//   when NUM_BUCKETS is not a power of two, bucket head read, walk start,
//   a registered entry read and a compare per chain entry visited, update
//   decision, a link step for an append or a remove, and response load.
//   A new request is taken only once the last one has loaded its response.
//   The entry memories have one read port; the walk is bound by them.
//   Reset: a clearing pass over all NUM_ENTRIES entries rebuilds the free list
//   links (entry i points to i+1); bucket head valid bits clear at once.
//   Requests are stalled during the pass.
//   When the receiver stalls, the response holds in rsp_ registers; a newer
//   request runs up to its response step and waits there.
// ----------------------------------------------------------------------------
module chained_hash_map_engine_core #(
   parameter int NUM_BUCKETS = chmap_pkg::NumBucketsDefault,
   parameter int NUM_ENTRIES = chmap_pkg::NumEntriesDefault
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [1:0]                             req_command,
   input  logic [chmap_pkg::KeyWidth-1:0]         req_lookup_key,
   input  logic signed [chmap_pkg::ValueWidth-1:0] req_data_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [chmap_pkg::ValueWidth-1:0] rsp_read_value,
   output logic                                   rsp_key_found,
   output logic                                   rsp_pool_full
);
   localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int EW = $clog2(NUM_ENTRIES);
   localparam int LW = EW + 1;   // link: index or null
   localparam int KW = chmap_pkg::KeyWidth;
   localparam int VW = chmap_pkg::ValueWidth;
   localparam logic [LW-1:0] LinkNull = LW'(NUM_ENTRIES);

   typedef enum logic [9:0] {
      ST_CLEAR  = 10'b0000000001,
      ST_IDLE   = 10'b0000000010,
      ST_BUCKET = 10'b0000000100,  // bucket index mod (multiply by reciprocal)
      ST_HREAD  = 10'b0000001000,  // registered bucket head read
      ST_HEAD   = 10'b0000010000,
      ST_READ   = 10'b0000100000,
      ST_CMP    = 10'b0001000000,
      ST_ALLOC  = 10'b0010000000,
      ST_LINK   = 10'b0100000000,
      ST_RESP   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   // entry memories
   logic [KW-1:0] key_mem [NUM_ENTRIES];
   logic [VW-1:0] val_mem [NUM_ENTRIES];
   logic [LW-1:0] link_mem [NUM_ENTRIES];
   logic [LW-1:0] heads_ff [NUM_BUCKETS];
   logic [NUM_BUCKETS-1:0] head_ok_ff;   // head valid; invalid reads null

   logic [1:0]    cmd_ff;
   logic [KW-1:0] key_ff;
   logic [VW-1:0] dval_ff;
   logic [BW-1:0] bkt_ff, bkt_in;
   logic [LW-1:0] cur_ff, cur_in, prev_ff, prev_in;
   logic [LW-1:0] free_head_ff, free_head_in;
   logic [LW-1:0] free_cnt_ff, free_cnt_in;
   logic [LW-1:0] steps_ff, steps_in;
   logic [EW-1:0] clr_ff;
   logic          found_ff, found_in;
   logic [KW-1:0] rk_ff;
   logic [VW-1:0] rv_ff;
   logic [LW-1:0] rl_ff;

   // result held until the output register takes it
   logic [VW-1:0] res_val_ff, res_val_in;
   logic          res_full_ff, res_full_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0] rsp_val_ff, rsp_val_in;
   logic          rsp_found_ff, rsp_found_in, rsp_full_ff, rsp_full_in;

   // memory port control
   logic          mem_we_key, mem_we_val, mem_we_link;
   logic [EW-1:0] mem_addr, link_waddr;
   logic [KW-1:0] mem_wkey;
   logic [VW-1:0] mem_wval;
   logic [LW-1:0] mem_wlink;
   logic          head_we;
   logic [LW-1:0] head_wdata;

   logic [BW-1:0] key_bucket;
   logic [LW-1:0] head_rd_ff;
   logic [VW-1:0] old_val, new_val;
   logic          accept;

   // bucket = key mod NUM_BUCKETS; power of two is a mask, else the quotient
   // comes from a reciprocal multiply, then one multiply-subtract gives the rest
   logic [KW-1:0] rem_ff, rem_in;
   logic [KW-1:0] quo_ff, quo_in;
   logic          div_ph_ff, div_ph_in;
   logic [63:0]   red_prod;
   localparam bit Pow2 = (NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0;
   localparam logic [KW-1:0] NbK = KW'(NUM_BUCKETS);
   localparam int RecipShift = KW + BW;
   localparam logic [32:0] RecipMul =
      33'(((64'd1 << RecipShift) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS));

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign key_bucket = Pow2 ? bkt_ff : rem_ff[BW-1:0];
   assign red_prod  = 64'(rem_ff) * 64'(RecipMul);
   assign old_val   = found_ff ? rv_ff : {VW{1'b1}};
   assign new_val   = (cmd_ff == chmap_pkg::CMD_INCR) ? old_val + dval_ff : dval_ff;

   always_comb begin
      state_in = state_ff;
      bkt_in = bkt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      div_ph_in = div_ph_ff;
      cur_in = cur_ff;
      prev_in = prev_ff;
      steps_in = steps_ff;
      found_in = found_ff;
      free_head_in = free_head_ff;
      free_cnt_in = free_cnt_ff;
      res_val_in = res_val_ff;
      res_full_in = res_full_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_val_in = rsp_val_ff;
      rsp_found_in = rsp_found_ff;
      rsp_full_in = rsp_full_ff;
      mem_we_key = 1'b0;
      mem_we_val = 1'b0;
      mem_we_link = 1'b0;
      mem_addr = cur_ff[EW-1:0];
      link_waddr = cur_ff[EW-1:0];
      mem_wkey = key_ff;
      mem_wval = new_val;
      mem_wlink = LinkNull;
      head_we = 1'b0;
      head_wdata = LinkNull;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we_link = 1'b1;
            link_waddr = clr_ff;
            mem_wlink = LW'(clr_ff) + LW'(1);
            if (clr_ff == EW'(NUM_ENTRIES - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               bkt_in = req_lookup_key[BW-1:0];
               rem_in = req_lookup_key;
               div_ph_in = 1'b0;
               found_in = 1'b0;
               prev_in = LinkNull;
               steps_in = '0;
               state_in = Pow2 ? ST_HREAD : ST_BUCKET;
            end
         end
         ST_BUCKET: begin
            // first phase: quotient; second phase: remainder
            if (!div_ph_ff) begin
               quo_in = KW'(red_prod >> RecipShift);
               div_ph_in = 1'b1;
            end else begin
               rem_in = rem_ff - KW'(quo_ff * NbK);
               state_in = ST_HREAD;
            end
         end
         ST_HREAD: begin
            state_in = ST_HEAD;
         end
         ST_HEAD: begin
            cur_in = head_rd_ff;
            state_in = (head_rd_ff == LinkNull) ? ST_ALLOC : ST_READ;
         end
         ST_READ: begin
            mem_addr = cur_ff[EW-1:0];
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (rk_ff == key_ff) begin
               found_in = 1'b1;
               state_in = ST_ALLOC;
            end else begin
               prev_in = cur_ff;
               cur_in = rl_ff;
               steps_in = steps_ff + LW'(1);
               if (rl_ff >= LinkNull || steps_ff + LW'(1) == LinkNull) begin
                  state_in = ST_ALLOC;
                  cur_in = LinkNull;
               end else state_in = ST_READ;
            end
         end
         ST_ALLOC: begin
            // decide and apply the command
            res_val_in = '0;
            res_full_in = 1'b0;
            state_in = ST_RESP;
            unique case (cmd_ff)
               chmap_pkg::CMD_GET: res_val_in = old_val;
               chmap_pkg::CMD_REMOVE: begin
                  if (found_ff) begin
                     if (prev_ff == LinkNull) begin
                        head_we = 1'b1;
                        head_wdata = rl_ff;
                     end else begin
                        mem_we_link = 1'b1;
                        link_waddr = prev_ff[EW-1:0];
                        mem_wlink = rl_ff;
                     end
                     state_in = ST_LINK;
                  end
               end
               default: begin
                  if (found_ff) begin
                     mem_we_val = 1'b1;
                     mem_addr = cur_ff[EW-1:0];
                  end else if (free_cnt_ff == '0 || free_head_ff >= LinkNull) begin
                     res_full_in = 1'b1;
                  end else begin
                     mem_addr = free_head_ff[EW-1:0];
                     cur_in = free_head_ff;
                     state_in = ST_LINK;
                  end
               end
            endcase
         end
         ST_LINK: begin
            state_in = ST_RESP;
            if (cmd_ff == chmap_pkg::CMD_REMOVE) begin
               mem_we_link = 1'b1;
               link_waddr = cur_ff[EW-1:0];
               mem_wlink = free_head_ff;
               free_head_in = cur_ff;
               if (free_cnt_ff < LinkNull) free_cnt_in = free_cnt_ff + LW'(1);
            end else begin
               // new entry at cur_ff (was free head); rl_ff holds its link
               mem_addr = cur_ff[EW-1:0];
               mem_we_key = 1'b1;
               mem_we_val = 1'b1;
               free_head_in = rl_ff;
               free_cnt_in = free_cnt_ff - LW'(1);
               if (prev_ff == LinkNull) begin
                  head_we = 1'b1;
                  head_wdata = cur_ff;
               end else begin
                  mem_we_link = 1'b1;
                  link_waddr = prev_ff[EW-1:0];
                  mem_wlink = cur_ff;
               end
            end
         end
         ST_RESP: begin
            // load when the output register is empty or drains this edge
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_val_in = res_val_ff;
               rsp_found_in = found_ff;
               rsp_full_in = res_full_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // new entry link must be null: written in a second port-free slot below
   logic new_null_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         head_ok_ff <= '0;
         free_head_ff <= '0;
         free_cnt_ff <= LinkNull;
         rsp_valid_ff <= 1'b0;
         new_null_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_ff + EW'(1);
         free_head_ff <= free_head_in;
         free_cnt_ff <= free_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (head_we) head_ok_ff[key_bucket] <= 1'b1;
         new_null_ff <= (state_ff == ST_LINK) && (cmd_ff != chmap_pkg::CMD_REMOVE);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_command;
         key_ff <= req_lookup_key;
         dval_ff <= req_data_value;
      end
      bkt_ff <= bkt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ph_ff <= div_ph_in;
      cur_ff <= cur_in;
      prev_ff <= prev_in;
      steps_ff <= steps_in;
      found_ff <= found_in;
      res_val_ff <= res_val_in;
      res_full_ff <= res_full_in;
      rsp_val_ff <= rsp_val_in;
      rsp_found_ff <= rsp_found_in;
      rsp_full_ff <= rsp_full_in;
      if (head_we) heads_ff[key_bucket] <= head_wdata;
      head_rd_ff <= head_ok_ff[key_bucket] ? heads_ff[key_bucket] : LinkNull;
   end

   // entry memories: one address, registered read
   always_ff @(posedge clock) begin
      if (mem_we_key) key_mem[mem_addr] <= mem_wkey;
      if (mem_we_val) val_mem[mem_addr] <= mem_wval;
      rk_ff <= key_mem[mem_addr];
      rv_ff <= val_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (mem_we_link) link_mem[link_waddr] <= mem_wlink;
      else if (new_null_ff) link_mem[cur_ff[EW-1:0]] <= LinkNull;
      rl_ff <= link_mem[mem_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_read_value = rsp_val_ff;
   assign rsp_key_found = rsp_found_ff;
   assign rsp_pool_full = rsp_full_ff;
endmodule

FILE: src/chmap_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chmap_checker: port-level checks for the hash map engine
// Handshake and payload rules seen at the ports.
// ----------------------------------------------------------------------------
module chmap_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_read_value,
   input logic        rsp_key_found,
   input logic        rsp_pool_full
);
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (req_stall && !rsp_valid)) else $error("not quiet after reset");
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall) else $error("request not held off");
   a_full_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_pool_full && rsp_key_found)) else $error("full with hit");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_read_value) &&
      $stable(rsp_key_found) && $stable(rsp_pool_full)))
      else $error("stalled response changed");
endmodule

bind chained_hash_map_engine_core chmap_checker u_chmap_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_read_value(rsp_read_value),
   .rsp_key_found(rsp_key_found), .rsp_pool_full(rsp_pool_full)
);
